// ----- rtl/sparse_ilu_dependency_lister_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dependency lister
// Concurrent checks on clk_i, gated by rst_ni; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SPARSE_ILU_DEPENDENCY_LISTER_TOP_DEFINES_SVH
`define SPARSE_ILU_DEPENDENCY_LISTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// check that cond holds at every edge out of reset
`define SILD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
// check that trig implies cond at the same edge
`define SILD_ASSERT_IMPL(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("assertion failed");
`else
`define SILD_ASSERT_ALWAYS(label, cond)
`define SILD_ASSERT_IMPL(label, trig, cond)
`endif
`endif

// ----- rtl/sild_pkg.sv -----
// ----------------------------------------------------------------------------
// Dependency lister package
// Result kinds, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package sild_pkg;

  localparam int DefMaxRows       = 1024;
  localparam int DefMaxNonzeros   = 8192;
  localparam int DefMaxRowNonzeros = 32;

  localparam int IdxW   = 10;
  localparam int LocW   = 13;
  localparam int TotalW = 20;
  localparam logic [TotalW-1:0] TotalMax = '1;

  typedef enum logic [1:0] {
    KIND_PAIR = 2'd0,
    KIND_DIAG = 2'd1,
    KIND_END  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_STORE,
    ST_SCAN_RD,
    ST_SCAN_K,
    ST_KS,
    ST_KE,
    ST_Q_RD,
    ST_Q_CMP,
    ST_EMIT_PAIR,
    ST_DIAG,
    ST_EMIT_DIAG,
    ST_EMIT_END,
    ST_EMIT_ERR
  } state_e;

endpackage

// ----- rtl/sild_in_if.sv -----
// ----------------------------------------------------------------------------
// Nonzero input channel
// One word per stored nonzero: row, column, end-of-matrix mark.
// ----------------------------------------------------------------------------
interface sild_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] row;
  logic [9:0] column;
  logic       last_of_matrix;

  modport source (output valid, row, column, last_of_matrix, input ready);
  modport sink   (input valid, row, column, last_of_matrix, output ready);
endinterface

// ----- rtl/sild_out_if.sv -----
// ----------------------------------------------------------------------------
// Dependency result channel
// One word per dependency, end record or error record.
// ----------------------------------------------------------------------------
interface sild_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] first_loc;
  logic [12:0] second_loc;
  logic [19:0] dep_count;
  logic        last;

  modport source (output valid, kind, first_loc, second_loc, dep_count, last, input ready);
  modport sink   (input valid, kind, first_loc, second_loc, dep_count, last, output ready);
endinterface

// ----- rtl/sparse_ilu_dependency_lister_top.sv -----
// ----------------------------------------------------------------------------
// Sparse ILU(0) dependency lister
// Stores a CSR matrix stream and lists the storage positions that each
// nonzero's ILU(0) update depends on.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  in_i    | in  | row, column, last_of_matrix
//  out_o   | out | kind, first_loc, second_loc, dep_count, last
//
//  One nonzero at a time: row starts are written on a row open, the word is
//  stored, each earlier entry of its row is scanned and, per candidate column
//  k, the bounds of row k are read and its entries searched (max 32). These
//  reads share the column store's single read port.
//  Reset is asynchronous and clears only control state; the stores need none.
//  A result waits in the output register; the sequencer stalls only when the
//  next result is ready and the register is still full.
// ----------------------------------------------------------------------------
`include "sparse_ilu_dependency_lister_top_defines.svh"

module sparse_ilu_dependency_lister_top #(
  parameter int MAX_ROWS         = sild_pkg::DefMaxRows,
  parameter int MAX_NONZEROS     = sild_pkg::DefMaxNonzeros,
  parameter int MAX_ROW_NONZEROS = sild_pkg::DefMaxRowNonzeros
) (
  input logic clk_i,
  input logic rst_ni,
  sild_in_if.sink    in_i,
  sild_out_if.source out_o
);
  import sild_pkg::*;

  // position index, position counter, row-start index, diagonal index and search count widths
  localparam int PW  = $clog2(MAX_NONZEROS);
  localparam int PCW = $clog2(MAX_NONZEROS + 1);
  localparam int RSW = $clog2(MAX_ROWS + 1);
  localparam int DW  = $clog2(MAX_ROWS);
  localparam int QNW = $clog2(MAX_ROW_NONZEROS + 1);

  // storage
  logic [IdxW-1:0] col_mem [MAX_NONZEROS];
  logic [PW-1:0]   rs_mem  [MAX_ROWS + 1];
  logic [PW-1:0]   dg_mem  [MAX_ROWS];

  logic            col_we, col_re, rs_we, rs_re, dg_we, dg_re;
  logic [PW-1:0]   col_waddr, col_raddr;
  logic [IdxW-1:0] col_wdata, col_rdata_q;
  logic [RSW-1:0]  rs_waddr, rs_raddr;
  logic [PW-1:0]   rs_wdata, rs_rdata_q;
  logic [DW-1:0]   dg_waddr, dg_raddr;
  logic [PW-1:0]   dg_wdata, dg_rdata_q;

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_waddr] <= col_wdata;
    if (col_re) col_rdata_q <= col_mem[col_raddr];
    if (rs_we) rs_mem[rs_waddr] <= rs_wdata;
    if (rs_re) rs_rdata_q <= rs_mem[rs_raddr];
    if (dg_we) dg_mem[dg_waddr] <= dg_wdata;
    if (dg_re) dg_rdata_q <= dg_mem[dg_raddr];
  end

  // control and working registers
  state_e          state_q, state_d;
  logic [IdxW-1:0] row_q, row_d, col_q, col_d, cur_q, cur_d, fill_q, fill_d, k_q, k_d;
  logic            fin_q, fin_d, open_q, open_d;
  logic [PCW-1:0]  pos_q, pos_d, start_q, start_d, p_q, p_d, q_q, q_d, ke_q, ke_d;
  logic [QNW-1:0]  qn_q, qn_d;
  logic [TotalW-1:0] total_q, total_d;

  logic              ovalid_q, ovalid_d, olast_q, olast_d;
  kind_e             okind_q, okind_d;
  logic [LocW-1:0]   ofirst_q, ofirst_d, osecond_q, osecond_d;
  logic [TotalW-1:0] ocount_q, ocount_d;

  logic slot_free;
  logic in_fire;
  logic drop_in;
  logic [TotalW-1:0] total_p1, total_p2;

  assign slot_free = !ovalid_q || out_o.ready;
  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign total_p1 = (total_q == TotalMax) ? TotalMax : total_q + TotalW'(1);
  assign total_p2 = (total_q >= TotalMax - TotalW'(1)) ? TotalMax : total_q + TotalW'(2);

  assign drop_in = (32'(pos_q) >= MAX_NONZEROS) || (32'(in_i.row) >= MAX_ROWS)
                || (32'(in_i.column) >= MAX_ROWS);

  always_comb begin
    state_d = state_q;
    row_d = row_q; col_d = col_q; fin_d = fin_q; cur_d = cur_q; open_d = open_q;
    fill_d = fill_q; k_d = k_q; pos_d = pos_q; start_d = start_q; p_d = p_q;
    q_d = q_q; ke_d = ke_q; qn_d = qn_q; total_d = total_q;
    ovalid_d = ovalid_q && !out_o.ready;
    okind_d = okind_q; ofirst_d = ofirst_q; osecond_d = osecond_q;
    ocount_d = ocount_q; olast_d = olast_q;
    col_we = 1'b0; col_re = 1'b0; rs_we = 1'b0; rs_re = 1'b0; dg_we = 1'b0; dg_re = 1'b0;
    col_waddr = PW'(pos_q); col_wdata = col_q; col_raddr = PW'(p_q);
    rs_waddr = RSW'(row_q); rs_wdata = PW'(pos_q); rs_raddr = RSW'(k_q);
    dg_waddr = DW'(row_q); dg_wdata = PW'(pos_q); dg_raddr = DW'(col_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          row_d = in_i.row;
          col_d = in_i.column;
          fin_d = in_i.last_of_matrix;
          if (drop_in) begin
            state_d = ST_EMIT_ERR;
          end else if (!open_q || in_i.row > cur_q) begin
            // open a new row: sweep row starts up to it
            fill_d  = open_q ? cur_q + IdxW'(1) : '0;
            cur_d   = in_i.row;
            open_d  = 1'b1;
            start_d = pos_q;
            state_d = ST_FILL;
          end else if (in_i.row < cur_q) begin
            rs_we    = 1'b1;
            rs_waddr = RSW'(in_i.row);
            cur_d    = in_i.row;
            start_d  = pos_q;
            state_d  = ST_STORE;
          end else if (32'(pos_q - start_q) >= MAX_ROW_NONZEROS) begin
            state_d = ST_EMIT_ERR;
          end else begin
            state_d = ST_STORE;
          end
        end
      end
      ST_FILL: begin
        rs_we    = 1'b1;
        rs_waddr = RSW'(fill_q);
        fill_d   = fill_q + IdxW'(1);
        if (fill_q == row_q) state_d = ST_STORE;
      end
      ST_STORE: begin
        col_we = 1'b1;
        if (row_q == col_q) dg_we = 1'b1;
        p_d = start_q;
        state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (p_q == pos_q) begin
          state_d = ST_DIAG;
        end else begin
          col_re  = 1'b1;
          state_d = ST_SCAN_K;
        end
      end
      ST_SCAN_K: begin
        k_d = col_rdata_q;
        if (col_rdata_q < row_q && col_rdata_q < col_q) begin
          rs_re    = 1'b1;
          rs_raddr = RSW'(col_rdata_q);
          state_d  = ST_KS;
        end else begin
          p_d = p_q + PCW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_KS: begin
        q_d      = PCW'(rs_rdata_q);
        qn_d     = '0;
        rs_re    = 1'b1;
        rs_raddr = RSW'(k_q) + RSW'(1);
        state_d  = ST_KE;
      end
      ST_KE: begin
        ke_d    = PCW'(rs_rdata_q);
        state_d = ST_Q_RD;
      end
      ST_Q_RD: begin
        if (q_q < ke_q && 32'(qn_q) < MAX_ROW_NONZEROS && 32'(q_q) < MAX_NONZEROS) begin
          col_re    = 1'b1;
          col_raddr = PW'(q_q);
          state_d   = ST_Q_CMP;
        end else begin
          p_d = p_q + PCW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_Q_CMP: begin
        if (col_rdata_q == col_q) begin
          state_d = ST_EMIT_PAIR;
        end else begin
          q_d  = q_q + PCW'(1);
          qn_d = qn_q + QNW'(1);
          state_d = ST_Q_RD;
        end
      end
      ST_EMIT_PAIR: begin
        if (slot_free) begin
          ovalid_d = 1'b1; okind_d = KIND_PAIR;
          ofirst_d = LocW'(p_q); osecond_d = LocW'(q_q);
          ocount_d = '0; olast_d = 1'b0;
          total_d  = total_p2;
          p_d      = p_q + PCW'(1);
          state_d  = ST_SCAN_RD;
        end
      end
      ST_DIAG: begin
        if (row_q > col_q) begin
          dg_re   = 1'b1;
          state_d = ST_EMIT_DIAG;
        end else begin
          state_d = ST_EMIT_END;
        end
      end
      ST_EMIT_DIAG: begin
        if (slot_free) begin
          ovalid_d = 1'b1; okind_d = KIND_DIAG;
          ofirst_d = LocW'(dg_rdata_q); osecond_d = '0;
          ocount_d = '0; olast_d = 1'b0;
          total_d  = total_p1;
          state_d  = ST_EMIT_END;
        end
      end
      ST_EMIT_END: begin
        if (slot_free) begin
          ovalid_d = 1'b1; okind_d = KIND_END;
          ofirst_d = '0; osecond_d = '0;
          ocount_d = total_q; olast_d = 1'b1;
          pos_d    = pos_q + PCW'(1);
          state_d  = ST_IDLE;
          if (fin_q) begin
            pos_d = '0; total_d = '0; open_d = 1'b0; cur_d = '0;
          end
        end
      end
      ST_EMIT_ERR: begin
        if (slot_free) begin
          ovalid_d = 1'b1; okind_d = KIND_ERR;
          ofirst_d = '0; osecond_d = '0;
          ocount_d = total_q; olast_d = 1'b1;
          state_d  = ST_IDLE;
          if (fin_q) begin
            pos_d = '0; total_d = '0; open_d = 1'b0; cur_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      total_q  <= '0;
      open_q   <= 1'b0;
      cur_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      total_q  <= total_d;
      open_q   <= open_d;
      cur_q    <= cur_d;
      ovalid_q <= ovalid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    row_q <= row_d; col_q <= col_d; fin_q <= fin_d; fill_q <= fill_d; k_q <= k_d;
    start_q <= start_d; p_q <= p_d; q_q <= q_d; ke_q <= ke_d; qn_q <= qn_d;
    okind_q <= okind_d; ofirst_q <= ofirst_d; osecond_q <= osecond_d;
    ocount_q <= ocount_d; olast_q <= olast_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.kind       = okind_q;
  assign out_o.first_loc  = ofirst_q;
  assign out_o.second_loc = osecond_q;
  assign out_o.dep_count  = ocount_q;
  assign out_o.last       = olast_q;

  // checks
  `SILD_ASSERT_ALWAYS(a_pos_bound, 32'(pos_q) <= MAX_NONZEROS)
  `SILD_ASSERT_IMPL(a_fill_bound, state_q == ST_FILL, fill_q <= row_q)
  `SILD_ASSERT_IMPL(a_search_bound, state_q == ST_Q_CMP, 32'(qn_q) < MAX_ROW_NONZEROS)
  `SILD_ASSERT_IMPL(a_scan_bound, state_q == ST_SCAN_K, p_q < pos_q)

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Dependency lister testbench
// Streams CSR matrices into the lister and checks every dependency, end and
// error word against a local predictor of the ILU(0) dependency lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import sild_pkg::*;

  localparam int NumPos  = DefMaxNonzeros;
  localparam int NumRows = DefMaxRows;
  localparam int RowCap  = DefMaxRowNonzeros;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    kind_e             kind;
    logic [LocW-1:0]   first_loc;
    logic [LocW-1:0]   second_loc;
    logic [TotalW-1:0] dep_count;
    logic              last;
  } dep_word_t;

  logic clk;
  logic rst_n;

  sild_in_if  in_if ();
  sild_out_if out_if ();

  sparse_ilu_dependency_lister_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // Predictor state: a shadow copy of the stores and counters.
  logic [IdxW-1:0] col_mem   [NumPos];
  logic [LocW-1:0] start_mem [NumRows+1];
  logic [LocW-1:0] diag_mem  [NumRows];
  int              next_pos;
  int              open_row;
  bit              row_is_open;
  int              dep_total;

  dep_word_t dep_q[$];

  int  err_count;
  int  words_sent;
  int  words_checked;
  int  drops_sent;
  int  send_gap_pct;
  int  stall_pct;
  int  hold_cycles;
  longint cycle_count;

  // Clock and the single reset pulse.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Run-length guard.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles, %0d words still expected",
                 cycle_count, dep_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic void add_deps(int n);
    dep_total = (dep_total + n > int'(TotalMax)) ? int'(TotalMax) : dep_total + n;
  endfunction

  function automatic void push_word(kind_e k, int a, int b, int cnt, bit lst);
    dep_word_t w;
    w.kind       = k;
    w.first_loc  = a[LocW-1:0];
    w.second_loc = b[LocW-1:0];
    w.dep_count  = cnt[TotalW-1:0];
    w.last       = lst;
    dep_q = {dep_q, w};
  endfunction

  // Work out every word one accepted nonzero causes and queue it.
  function automatic void predict_deps(logic [IdxW-1:0] row, logic [IdxW-1:0] col, bit fin);
    int  r_i;
    int  c_i;
    int  rs;
    int  pos;
    int  k;
    int  ks;
    int  ke;
    int  r;
    bit  drop;
    r_i  = row;
    c_i  = col;
    pos  = next_pos;
    rs   = 0;
    drop = (pos >= NumPos);
    if (!drop) begin
      if (!row_is_open || r_i > open_row) begin
        for (r = row_is_open ? open_row + 1 : 0; r <= r_i; r++) start_mem[r] = pos[LocW-1:0];
      end else if (r_i < open_row) begin
        start_mem[r_i] = pos[LocW-1:0];
      end
      row_is_open = 1'b1;
      open_row    = r_i;
      rs          = start_mem[r_i];
      if (rs > pos || pos - rs >= RowCap) drop = 1'b1;
    end
    if (drop) begin
      push_word(KIND_ERR, 0, 0, dep_total, 1'b1);
    end else begin
      col_mem[pos] = col;
      if (r_i == c_i) diag_mem[r_i] = pos[LocW-1:0];
      for (int p = rs; p < pos; p++) begin
        k = col_mem[p];
        if (k >= r_i || k >= c_i) continue;
        ks = start_mem[k];
        ke = start_mem[k+1];
        for (int q = ks; q < ke && q - ks < RowCap && q < NumPos; q++) begin
          if (col_mem[q] == col) begin
            push_word(KIND_PAIR, p, q, 0, 1'b0);
            add_deps(2);
            break;
          end
        end
      end
      if (r_i > c_i) begin
        push_word(KIND_DIAG, diag_mem[c_i], 0, 0, 1'b0);
        add_deps(1);
      end
      push_word(KIND_END, 0, 0, dep_total, 1'b1);
      next_pos = pos + 1;
    end
    if (fin) begin
      next_pos    = 0;
      dep_total   = 0;
      open_row    = 0;
      row_is_open = 1'b0;
    end
  endfunction

  // Offer one word and hold it until the lister takes it; then maybe idle.
  task automatic send_word(int row, int col, bit fin);
    int gap;
    in_if.valid          <= 1'b1;
    in_if.row            <= row[IdxW-1:0];
    in_if.column         <= col[IdxW-1:0];
    in_if.last_of_matrix <= fin;
    do @(posedge clk); while (!in_if.ready);
    predict_deps(row[IdxW-1:0], col[IdxW-1:0], fin);
    words_sent++;
    if ($urandom_range(99) < send_gap_pct) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every expected word to come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (dep_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a counted hold-off when asked.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Checker: compare each accepted word with the oldest expectation.
  initial begin
    dep_word_t got;
    dep_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.kind       = kind_e'(out_if.kind);
        got.first_loc  = out_if.first_loc;
        got.second_loc = out_if.second_loc;
        got.dep_count  = out_if.dep_count;
        got.last       = out_if.last;
        if (dep_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected word kind=%0d first=%0d second=%0d count=%0d last=%0b",
                   $time, got.kind, got.first_loc, got.second_loc, got.dep_count, got.last);
        end else begin
          want = dep_q.pop_front();
          words_checked++;
          if (got !== want) begin
            err_count++;
            $display("%0t: mismatch expected kind=%0d first=%0d second=%0d count=%0d last=%0b",
                     $time, want.kind, want.first_loc, want.second_loc, want.dep_count,
                     want.last);
            $display("%0t:          actual   kind=%0d first=%0d second=%0d count=%0d last=%0b",
                     $time, got.kind, got.first_loc, got.second_loc, got.dep_count, got.last);
          end
        end
      end
    end
  end

  // Directed matrix: extreme indices, pairs, diagonal words, skipped rows,
  // a jump to the top row and a decreasing row on the matrix end.
  task automatic test_directed();
    send_word(0, 0, 0);     send_word(0, 1, 0);
    send_word(0, 5, 0);     send_word(0, 1023, 0);
    send_word(1, 0, 0);     send_word(1, 1, 0);     send_word(1, 2, 0);
    send_word(2, 0, 0);     send_word(2, 1, 0);
    send_word(2, 2, 0);     send_word(2, 3, 0);
    send_word(3, 1, 0);     send_word(3, 3, 0);
    send_word(1023, 0, 0);  send_word(1023, 2, 0);  send_word(1023, 1023, 0);
    // Row below the open one: only its own start moves.
    send_word(4, 1, 0);     send_word(4, 4, 1);
    drain();
  endtask

  // One row fills past its capacity: the excess words come back as errors.
  task automatic test_row_overflow();
    for (int c = 0; c < RowCap + 2; c++) begin
      send_word(0, c, 0);
      if (c >= RowCap) drops_sent++;
    end
    send_word(1, 0, 0);
    send_word(1, 1, 1);
    drain();
  endtask

  // A well-formed random matrix: every listed row holds its diagonal, lower
  // columns name earlier rows, upper columns are free.
  task automatic send_random_matrix(bit sparse_rows);
    int rows[$];
    int cols[$];
    int nrows;
    int r;
    int c;
    int nup;
    nrows = $urandom_range(2, 10);
    r = sparse_rows ? $urandom_range(0, 20) : 0;
    for (int i = 0; i < nrows && r < NumRows; i++) begin
      rows = {rows, r};
      r += sparse_rows ? $urandom_range(1, 250) : 1;
    end
    if (sparse_rows && $urandom_range(1) == 1 && rows[rows.size()-1] != NumRows - 1)
      rows = {rows, NumRows - 1};
    for (int i = 0; i < rows.size(); i++) begin
      cols.delete();
      for (int j = 0; j < i; j++) if ($urandom_range(99) < 55) cols = {cols, rows[j]};
      cols = {cols, rows[i]};
      nup = $urandom_range(0, 3);
      c = rows[i];
      for (int j = 0; j < nup; j++) begin
        c += $urandom_range(1, 300);
        if (c >= NumRows) break;
        cols = {cols, c};
      end
      for (int j = 0; j < cols.size(); j++)
        send_word(rows[i], cols[j], (i == rows.size() - 1) && (j == cols.size() - 1));
    end
  endtask

  task automatic test_random(int n_words, int gap_pct, int stall_p);
    int stop_at;
    send_gap_pct = gap_pct;
    stall_pct    = stall_p;
    stop_at      = words_sent + n_words;
    while (words_sent < stop_at) send_random_matrix($urandom_range(99) < 40);
    drain();
  endtask

  // Hold the receiver off while the sender keeps offering: the lister fills
  // its output and stalls the input. Then pause until everything is back.
  task automatic test_backpressure();
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_cycles  = 600;
    send_random_matrix(1'b0);
    send_random_matrix(1'b1);
    drain();
  endtask

  initial begin
    err_count            = 0;
    words_sent           = 0;
    words_checked        = 0;
    drops_sent           = 0;
    hold_cycles          = 0;
    send_gap_pct         = 0;
    stall_pct            = 0;
    next_pos             = 0;
    open_row             = 0;
    row_is_open          = 1'b0;
    dep_total            = 0;
    in_if.valid          <= 1'b0;
    in_if.row            <= '0;
    in_if.column         <= '0;
    in_if.last_of_matrix <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    test_directed();
    test_row_overflow();
    test_random(35, 0, 0);
    test_random(35, 60, 0);
    test_random(35, 0, 60);
    test_random(35, 20, 20);
    test_backpressure();

    repeat (300) @(posedge clk);
    $display("covered %0d nonzero words (%0d over row capacity), %0d result words checked",
             words_sent, drops_sent, words_checked);
    $display("idle phases: none, sender gaps, receiver stalls, both; one long hold-off");
    if (err_count == 0 && dep_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sild_pkg.sv
rtl/sild_in_if.sv
rtl/sild_out_if.sv
rtl/sparse_ilu_dependency_lister_top.sv
tb/tb_top.sv
